>>> src/tumbling_window_averager_unit_assert.svh
// Assertion macros for the tumbling window averager.
// Clocked on clk, disabled while rst_n is low; the including module supplies both.
`ifndef TUMBLING_WINDOW_AVERAGER_UNIT_ASSERT_SVH
`define TUMBLING_WINDOW_AVERAGER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TWA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twa assertion failed");

// Next-cycle implication.
`define TWA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twa assertion failed");

`endif

>>> src/twa_pkg.sv
// Shared types and constants for the tumbling window averager.
// No dependencies; used by the divider and the top level.
package twa_pkg;

    localparam int FEATURE_COUNT  = 4;
    localparam int VALUE_BITS     = 32;
    localparam int STAMP_BITS     = 32;
    localparam int LABEL_BITS     = 16;
    localparam int FEAT_IDX_BITS  = $clog2(FEATURE_COUNT);
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LABEL_ENABLED = CFG_INDEX_BITS'(1);

    localparam logic [STAMP_BITS-1:0] WIDTH_RESET = STAMP_BITS'(1000);

    typedef struct packed {
        logic        [STAMP_BITS-1:0]    stamp;
        logic signed [VALUE_BITS-1:0]    sample_0;
        logic signed [VALUE_BITS-1:0]    sample_1;
        logic signed [VALUE_BITS-1:0]    sample_2;
        logic signed [VALUE_BITS-1:0]    sample_3;
        logic        [FEATURE_COUNT-1:0] present_mask;
        logic signed [LABEL_BITS-1:0]    class_tag;
        logic                            end_of_stream;
    } sample_t;

    typedef struct packed {
        logic        [STAMP_BITS-1:0] window_begin;
        logic signed [VALUE_BITS-1:0] mean_0;
        logic signed [VALUE_BITS-1:0] mean_1;
        logic signed [VALUE_BITS-1:0] mean_2;
        logic signed [VALUE_BITS-1:0] mean_3;
        logic signed [LABEL_BITS-1:0] top_label;
        logic                         last_of_run;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [STAMP_BITS-1:0]     value;
    } cfg_write_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> src/twa_chan_if.sv
// Valid/ready channel carrying one payload of type data_t.
// Depends on nothing; payload types come from twa_pkg at instantiation.
interface twa_chan_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> src/twa_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on twa_pkg for the status struct.
module twa_div #(
    parameter int DIVIDEND_BITS = 48,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output twa_pkg::div_stat_t       stat,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder
);
    import twa_pkg::*;

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_BITS'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: shift the dividend out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/tumbling_window_averager_unit.sv
// Tumbling window averager: groups time-stamped samples into fixed windows, emits means.
// Depends on twa_pkg, twa_chan_if, twa_div and tumbling_window_averager_unit_assert.svh.
// A close or a flush runs the divider once per non-empty feature; a close runs it once more
// for the new origin, and a sample that closes a window and ends the stream does both.
// Window-port stalls can hold either sequence.
// Reset (rst_n, async, active low) clears all window state; width 1000, labels enabled.
`include "tumbling_window_averager_unit_assert.svh"

module tumbling_window_averager_unit #(
    parameter int COUNT_BITS = 16
) (
    input logic      clk,
    input logic      rst_n,
    twa_chan_if.sink   samples,
    twa_chan_if.source windows,
    twa_chan_if.sink   cfg
);
    import twa_pkg::*;

    // Sums hold up to 2^COUNT_BITS - 1 values of 32 bits without overflow.
    localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;
    localparam logic [FEAT_IDX_BITS-1:0] LAST_FEAT = FEAT_IDX_BITS'(FEATURE_COUNT - 1);

    // Sequencer codes.
    localparam logic [2:0] S_IDLE      = 3'd0;  // wait for a sample transfer
    localparam logic [2:0] S_ADD       = 3'd1;  // accumulate the held sample
    localparam logic [2:0] S_MEAN_GO   = 3'd2;  // launch the divider for one feature, or zero an empty one
    localparam logic [2:0] S_MEAN_WAIT = 3'd3;  // collect that feature's mean
    localparam logic [2:0] S_EMIT      = 3'd4;  // load the result register
    localparam logic [2:0] S_REM_GO    = 3'd5;  // launch stamp / width
    localparam logic [2:0] S_REM_WAIT  = 3'd6;  // new origin = stamp - remainder

    logic [2:0]                      state_reg;
    logic [STAMP_BITS-1:0]           width_reg;
    logic                            label_en_reg;
    logic [STAMP_BITS-1:0]           origin_reg;
    logic signed [SUM_BITS-1:0]      sum_reg   [FEATURE_COUNT];
    logic [COUNT_BITS-1:0]           count_reg [FEATURE_COUNT];
    logic signed [LABEL_BITS-1:0]    peak_reg;
    logic                            seen_reg;
    logic                            started_reg;
    logic                            touched_reg;
    logic [FEAT_IDX_BITS-1:0]        feat_idx_reg;
    logic                            flush_reg;
    logic                            neg_reg;
    logic signed [VALUE_BITS-1:0]    mean_reg  [FEATURE_COUNT];
    logic                            out_valid_reg;
    result_t                         out_reg;
    sample_t                         item_reg;

    logic                            sample_fire;
    logic                            out_fire;
    logic                            out_free;
    logic [STAMP_BITS-1:0]           width_eff;
    logic [STAMP_BITS:0]             win_end;
    logic                            close_hit;
    logic signed [VALUE_BITS-1:0]    item_value [FEATURE_COUNT];
    logic [FEATURE_COUNT-1:0]        add_hit;
    logic                            touched_after;
    logic signed [SUM_BITS-1:0]      sum_sel;
    logic [COUNT_BITS-1:0]           count_sel;
    logic [SUM_BITS-1:0]             sum_mag;
    logic [VALUE_BITS-1:0]           quo_low;
    logic signed [VALUE_BITS-1:0]    mean_new;
    logic                            counts_empty;
    result_t                         result_next;

    logic                            div_start;
    logic [SUM_BITS-1:0]             div_dividend;
    logic [STAMP_BITS-1:0]           div_divisor;
    div_stat_t                       div_stat;
    logic [SUM_BITS-1:0]             div_quo;
    logic [STAMP_BITS-1:0]           div_rem;

    // One shared divider: feature means and the stamp remainder for the next origin.
    twa_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (STAMP_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Handshakes. Take a sample whenever the sequencer idles, even with a result pending.
    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign windows.valid = out_valid_reg;
    assign windows.data  = out_reg;

    assign sample_fire = samples.valid && samples.ready;
    assign out_fire    = windows.valid && windows.ready;
    assign out_free    = !out_valid_reg || windows.ready;

    always_comb
    begin
        // A zero width behaves as one tick.
        width_eff = (width_reg == '0) ? STAMP_BITS'(1) : width_reg;
        // Compare without wrap: origin + width carries into bit 32.
        win_end   = {1'b0, origin_reg} + {1'b0, width_eff};
        close_hit = started_reg && ({1'b0, samples.data.stamp} >= win_end);

        item_value[0] = item_reg.sample_0;
        item_value[1] = item_reg.sample_1;
        item_value[2] = item_reg.sample_2;
        item_value[3] = item_reg.sample_3;

        counts_empty = 1'b1;
        for (int k = 0; k < FEATURE_COUNT; k++)
        begin
            // Drop values once the count saturates.
            add_hit[k] = item_reg.present_mask[k] && (count_reg[k] != COUNT_MAX);
            if (count_reg[k] != '0)
            begin
                counts_empty = 1'b0;
            end
        end
        touched_after = touched_reg || (|add_hit);

        sum_sel   = sum_reg[feat_idx_reg];
        count_sel = count_reg[feat_idx_reg];
        sum_mag   = sum_sel[SUM_BITS-1] ? SUM_BITS'(-sum_sel) : SUM_BITS'(sum_sel);

        // Mean of magnitudes, sign restored: truncates toward zero.
        quo_low  = div_quo[VALUE_BITS-1:0];
        mean_new = neg_reg ? VALUE_BITS'(-quo_low) : VALUE_BITS'(quo_low);

        div_start    = ((state_reg == S_MEAN_GO) && (count_sel != '0))
                       || (state_reg == S_REM_GO);
        div_dividend = (state_reg == S_REM_GO) ? SUM_BITS'(item_reg.stamp) : sum_mag;
        div_divisor  = (state_reg == S_REM_GO) ? width_eff : STAMP_BITS'(count_sel);

        result_next.window_begin = origin_reg;
        result_next.mean_0       = mean_reg[0];
        result_next.mean_1       = mean_reg[1];
        result_next.mean_2       = mean_reg[2];
        result_next.mean_3       = mean_reg[3];
        result_next.top_label    = seen_reg ? peak_reg : '0;
        // A close is followed by a flush whenever the sample ends the stream.
        result_next.last_of_run  = flush_reg || !item_reg.end_of_stream;
    end

    // Hold the transferred sample for the rest of its sequence.
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            item_reg <= samples.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            label_en_reg  <= 1'b1;
            origin_reg    <= '0;
            peak_reg      <= '0;
            seen_reg      <= 1'b0;
            started_reg   <= 1'b0;
            touched_reg   <= 1'b0;
            feat_idx_reg  <= '0;
            flush_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int k = 0; k < FEATURE_COUNT; k++)
            begin
                sum_reg[k]   <= '0;
                count_reg[k] <= '0;
                mean_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    REG_WINDOW_WIDTH:  width_reg    <= cfg.data.value;
                    REG_LABEL_ENABLED: label_en_reg <= cfg.data.value[0];
                    default:           ;
                endcase
            end

            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_fire)
                    begin
                        if (!started_reg)
                        begin
                            // First sample opens the stream at its own stamp.
                            started_reg <= 1'b1;
                            origin_reg  <= samples.data.stamp;
                            state_reg   <= S_ADD;
                        end
                        else if (close_hit)
                        begin
                            flush_reg    <= 1'b0;
                            feat_idx_reg <= '0;
                            state_reg    <= S_MEAN_GO;
                        end
                        else
                        begin
                            state_reg <= S_ADD;
                        end
                    end
                end

                S_ADD:
                begin
                    for (int k = 0; k < FEATURE_COUNT; k++)
                    begin
                        if (add_hit[k])
                        begin
                            sum_reg[k]   <= sum_reg[k] + SUM_BITS'(item_value[k]);
                            count_reg[k] <= count_reg[k] + COUNT_BITS'(1);
                        end
                    end
                    if (label_en_reg)
                    begin
                        if (!seen_reg || (item_reg.class_tag > peak_reg))
                        begin
                            peak_reg <= item_reg.class_tag;
                        end
                        seen_reg <= 1'b1;
                    end
                    touched_reg <= touched_after;

                    if (item_reg.end_of_stream)
                    begin
                        if (touched_after)
                        begin
                            flush_reg    <= 1'b1;
                            feat_idx_reg <= '0;
                            state_reg    <= S_MEAN_GO;
                        end
                        else
                        begin
                            // Untouched stream: drop it silently and start afresh.
                            origin_reg  <= '0;
                            started_reg <= 1'b0;
                            touched_reg <= 1'b0;
                            peak_reg    <= '0;
                            seen_reg    <= 1'b0;
                            for (int k = 0; k < FEATURE_COUNT; k++)
                            begin
                                sum_reg[k]   <= '0;
                                count_reg[k] <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_MEAN_GO:
                begin
                    neg_reg <= sum_sel[SUM_BITS-1];
                    if (count_sel == '0)
                    begin
                        // Feature had no values in this window.
                        mean_reg[feat_idx_reg] <= '0;
                        if (feat_idx_reg == LAST_FEAT)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            feat_idx_reg <= feat_idx_reg + FEAT_IDX_BITS'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_MEAN_WAIT;
                    end
                end

                S_MEAN_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        mean_reg[feat_idx_reg] <= mean_new;
                        if (feat_idx_reg == LAST_FEAT)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            feat_idx_reg <= feat_idx_reg + FEAT_IDX_BITS'(1);
                            state_reg    <= S_MEAN_GO;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= result_next;
                        if (flush_reg)
                        begin
                            // End of stream: return every window register to reset.
                            origin_reg  <= '0;
                            started_reg <= 1'b0;
                            touched_reg <= 1'b0;
                            peak_reg    <= '0;
                            seen_reg    <= 1'b0;
                            for (int k = 0; k < FEATURE_COUNT; k++)
                            begin
                                sum_reg[k]   <= '0;
                                count_reg[k] <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_REM_GO;
                        end
                    end
                end

                S_REM_GO:
                begin
                    state_reg <= S_REM_WAIT;
                end

                S_REM_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        // Floor the stamp to a multiple of the width and open a fresh window.
                        origin_reg  <= item_reg.stamp - div_rem;
                        touched_reg <= 1'b1;
                        peak_reg    <= '0;
                        seen_reg    <= 1'b0;
                        for (int k = 0; k < FEATURE_COUNT; k++)
                        begin
                            sum_reg[k]   <= '0;
                            count_reg[k] <= '0;
                        end
                        state_reg <= S_ADD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A transfer always takes the sequencer out of idle.
    `TWA_ASSERT_NEXT(a_accept_leaves_idle, sample_fire, state_reg != S_IDLE)
    // The divider is never restarted while it is working.
    `TWA_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy)
    // An untouched window has accumulated no values.
    `TWA_ASSERT_IMPL(a_untouched_empty, !touched_reg, counts_empty)

endmodule
